/* design/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU usage counter table
// Field widths, the saturation limit and the structs that move between
// the controller and the cell chain.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int KEY_W           = 64;
   localparam int COUNT_W         = 15;
   localparam int SLOT_OUT_W      = 3;
   localparam int SLOT_IDX_W      = 6;   // covers up to 64 entries
   localparam int ENTRIES_DEFAULT = 8;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 15'd32767;
   // minimum search starts one above any legal count
   localparam logic [COUNT_W:0]   LEAST_INIT = 16'd32768;

   typedef enum logic {
      PH_MATCH,
      PH_FAV
   } scan_phase_type;

   // token handed from cell to cell
   typedef struct packed {
      logic                  valid;
      scan_phase_type        phase;
      logic [KEY_W-1:0]      key;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic [COUNT_W-1:0]    hit_cnt;
      logic [COUNT_W:0]      least_val;
      logic [SLOT_IDX_W-1:0] least_idx;
      logic [KEY_W-1:0]      fav_key;
      logic [COUNT_W-1:0]    fav_cnt;
   } scan_type;

   // update broadcast to every cell
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] slot;
      logic [KEY_W-1:0]      key;
   } update_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] cnt);
      sat_inc = (cnt == COUNT_LIMIT) ? COUNT_LIMIT : cnt + COUNT_W'(1);
   endfunction

endpackage

/* design/lfu_if.sv */
// ----------------------------------------------------------------------------
// lfu_if: request and response channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   import lfu_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] use_key;

   modport source (output valid, output use_key, input ready);
   modport sink   (input valid, input use_key, output ready);
endinterface

interface lfu_rsp_if;
   import lfu_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  was_hit;
   logic [SLOT_OUT_W-1:0] slot_used;
   logic [COUNT_W-1:0]    slot_count;
   logic [KEY_W-1:0]      favourite_key;
   logic [COUNT_W-1:0]    favourite_count;

   modport source (output valid, output was_hit, output slot_used, output slot_count,
                   output favourite_key, output favourite_count, input ready);
   modport sink   (input valid, input was_hit, input slot_used, input slot_count,
                   input favourite_key, input favourite_count, output ready);
endinterface

/* design/lfu_usage_counter_table.sv */
// ----------------------------------------------------------------------------
// lfu_usage_counter_table: LFU usage counter table
// Top level: request control, cell chain and response register.
// ----------------------------------------------------------------------------
// Each request walks a token down a chain of ENTRIES cells twice: once to find
// the first matching key (or the first entry with the least count), then,
// after the chosen entry is bumped or replaced, once more to find the first
// entry with the greatest nonzero count; both passes move the token one cell
// per cycle. A new request is taken only when the last one has been
// loaded into the response register. A finished response waits in its own
// register, so the next request can be taken while it is still unread. The
// table resets to key 0, count 0 in every entry; key 0 is an ordinary key.
// ----------------------------------------------------------------------------
module lfu_usage_counter_table #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lfu_req_if.sink   req_chan,
   lfu_rsp_if.source rsp_chan
);
   import lfu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_FAV_GO,
      ST_FAV,
      ST_OUT
   } state_type;

   state_type state_ff;

   scan_type   chain [ENTRIES+1];
   update_type upd;
   scan_type   tail;

   logic                  hit_ff;
   logic [SLOT_IDX_W-1:0] slot_ff;
   logic [COUNT_W-1:0]    slot_cnt_ff;
   logic [KEY_W-1:0]      fav_key_ff;
   logic [COUNT_W-1:0]    fav_cnt_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [COUNT_W-1:0]    rsp_cnt_ff;
   logic [KEY_W-1:0]      rsp_fav_key_ff;
   logic [COUNT_W-1:0]    rsp_fav_cnt_ff;

   logic req_take;
   logic match_done;
   logic fav_done;
   logic rsp_load;

   assign tail       = chain[ENTRIES];
   assign req_take   = req_chan.valid && (state_ff == ST_IDLE);
   assign match_done = (state_ff == ST_MATCH) && tail.valid && (tail.phase == PH_MATCH);
   assign fav_done   = (state_ff == ST_FAV) && tail.valid && (tail.phase == PH_FAV);
   // response register is free or being read this cycle
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // token injected at the head of the chain
   always_comb begin
      chain[0]           = '0;
      chain[0].phase     = PH_MATCH;
      chain[0].least_val = LEAST_INIT;
      if (req_take) begin
         chain[0].valid = 1'b1;
         chain[0].key   = req_chan.use_key;
      end else if (state_ff == ST_FAV_GO) begin
         chain[0].valid = 1'b1;
         chain[0].phase = PH_FAV;
      end
   end

   // write back as the match token leaves the chain
   always_comb begin
      upd.valid = match_done;
      upd.hit   = tail.hit;
      upd.slot  = tail.hit ? tail.hit_idx : tail.least_idx;
      upd.key   = tail.key;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lfu_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (chain[i]),
         .upd    (upd),
         .tok_out(chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  state_ff <= ST_MATCH;
               end
            end
            ST_MATCH: begin
               if (match_done) begin
                  state_ff <= ST_FAV_GO;
               end
            end
            ST_FAV_GO: begin
               state_ff <= ST_FAV;
            end
            ST_FAV: begin
               if (fav_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (match_done) begin
         hit_ff      <= tail.hit;
         slot_ff     <= upd.slot;
         slot_cnt_ff <= tail.hit ? sat_inc(tail.hit_cnt) : COUNT_W'(1);
      end
      if (fav_done) begin
         fav_key_ff <= tail.fav_key;
         fav_cnt_ff <= tail.fav_cnt;
      end
      if (rsp_load) begin
         rsp_hit_ff     <= hit_ff;
         rsp_slot_ff    <= slot_ff[SLOT_OUT_W-1:0];
         rsp_cnt_ff     <= slot_cnt_ff;
         rsp_fav_key_ff <= fav_key_ff;
         rsp_fav_cnt_ff <= fav_cnt_ff;
      end
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.was_hit         = rsp_hit_ff;
   assign rsp_chan.slot_used       = rsp_slot_ff;
   assign rsp_chan.slot_count      = rsp_cnt_ff;
   assign rsp_chan.favourite_key   = rsp_fav_key_ff;
   assign rsp_chan.favourite_count = rsp_fav_cnt_ff;

endmodule

/* design/lfu_cell.sv */
// ----------------------------------------------------------------------------
// lfu_cell: one table entry
// Holds a key and a use count, folds its entry into the passing token
// (match/least search or favourite search) and applies broadcast updates.
// ----------------------------------------------------------------------------
module lfu_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  lfu_pkg::scan_type   tok_in,
   input  lfu_pkg::update_type upd,
   output lfu_pkg::scan_type   tok_out
);
   import lfu_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(CELL_INDEX);

   logic [KEY_W-1:0]   key_ff;
   logic [COUNT_W-1:0] cnt_ff;
   scan_type           tok_ff;
   scan_type           tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      unique case (tok_in.phase)
         PH_MATCH: begin
            if (!tok_in.hit) begin
               if (key_ff == tok_in.key) begin
                  tok_in_next.hit     = 1'b1;
                  tok_in_next.hit_idx = MY_IDX;
                  tok_in_next.hit_cnt = cnt_ff;
               end else if ({1'b0, cnt_ff} < tok_in.least_val) begin
                  tok_in_next.least_val = {1'b0, cnt_ff};
                  tok_in_next.least_idx = MY_IDX;
               end
            end
         end
         PH_FAV: begin
            if (cnt_ff > tok_in.fav_cnt) begin
               tok_in_next.fav_cnt = cnt_ff;
               tok_in_next.fav_key = key_ff;
            end
         end
         default: tok_in_next = tok_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.phase     <= tok_in_next.phase;
      tok_ff.key       <= tok_in_next.key;
      tok_ff.hit       <= tok_in_next.hit;
      tok_ff.hit_idx   <= tok_in_next.hit_idx;
      tok_ff.hit_cnt   <= tok_in_next.hit_cnt;
      tok_ff.least_val <= tok_in_next.least_val;
      tok_ff.least_idx <= tok_in_next.least_idx;
      tok_ff.fav_key   <= tok_in_next.fav_key;
      tok_ff.fav_cnt   <= tok_in_next.fav_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         cnt_ff <= '0;
      end else if (upd.valid && upd.slot == MY_IDX) begin
         if (upd.hit) begin
            cnt_ff <= sat_inc(cnt_ff);
         end else begin
            key_ff <= upd.key;
            cnt_ff <= COUNT_W'(1);
         end
      end
   end

   assign tok_out = tok_ff;

endmodule
